/* rtl/generational_handle_allocator_top_assert.svh */
// Assertion macros shared by the checker files of the handle allocator.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("handle allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define GHA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("handle allocator check failed");

`endif

/* rtl/gha_pkg.sv */
// Shared types and constants of the generational handle allocator.
// Depends on nothing; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int GEN_BITS_DEF   = 12;
    localparam int OP_W           = 3;
    localparam int ST_W           = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_DESTROY   = 3'd1,
        OP_CHECK     = 3'd2,
        OP_READ      = 3'd3,
        OP_RESET_ALL = 3'd4
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_READ_ONLY = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_INVALID   = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RD1  = 2'd1,
        S_RD2  = 2'd2
    } state_t;

endpackage

`default_nettype wire

/* rtl/gha_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; instantiated for the generation words and the free list.
`timescale 1ns / 1ps
`default_nettype none

module gha_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 13
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/generational_handle_allocator_top.sv */
// The result is registered in S_RD1, or in S_RD2 for a create served from the free list
// (pop, then read of the popped generation word). A new request is taken only in S_IDLE,
// once the last result is loaded; the state machine waits while the output register holds
// a result not yet taken, and the read of the generation memory is registered.
// Reset clears the counters, read_only, the state and m_valid; the memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator_top #(
    parameter int INDEX_BITS = gha_pkg::INDEX_BITS_DEF,
    parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
    localparam int IN_W       = gha_pkg::OP_W + INDEX_BITS + GEN_BITS,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = gha_pkg::ST_W + 2 * INDEX_BITS + GEN_BITS + 1,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0 up: opcode, handle_index, handle_generation, zero padding.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0 up: status, out_index, out_generation, handle_ok,
    // capacity_used, zero padding.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // read_only register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    import gha_pkg::*;

    localparam logic [INDEX_BITS-1:0] NULL_INDEX = {INDEX_BITS{1'b1}};
    localparam logic [GEN_BITS-1:0]   GEN_MAX    = {GEN_BITS{1'b1}};

    state_t                state_reg, state_next;
    opcode_t               op_reg, op_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [GEN_BITS-1:0]   hgen_reg, hgen_next;
    logic [INDEX_BITS:0]   free_count_reg, free_count_next;
    logic [INDEX_BITS:0]   high_water_reg, high_water_next;
    logic [INDEX_BITS-1:0] gen_addr_reg, gen_addr_next;
    logic                  read_only_reg, read_only_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg, status_next;
    logic [INDEX_BITS-1:0] oidx_reg, oidx_next;
    logic [GEN_BITS-1:0]   ogen_reg, ogen_next;
    logic                  ok_reg, ok_next;
    logic [INDEX_BITS-1:0] cap_reg, cap_next;

    logic                  gen_we;
    logic [INDEX_BITS-1:0] gen_waddr, gen_raddr;
    logic [GEN_BITS:0]     gen_wdata, gen_rdata;
    logic                  stk_we;
    logic [INDEX_BITS-1:0] stk_waddr, stk_raddr, stk_rdata;
    logic [INDEX_BITS:0]   fc_minus1;
    logic [GEN_BITS:0]     gen_inc;
    logic                  out_free, out_load, live;

    gha_ram #(
        .ADDR_BITS(INDEX_BITS),
        .DATA_BITS(GEN_BITS + 1)
    ) u_gen_ram (
        .clk  (clk),
        .we   (gen_we),
        .waddr(gen_waddr),
        .wdata(gen_wdata),
        .raddr(gen_raddr),
        .rdata(gen_rdata)
    );

    gha_ram #(
        .ADDR_BITS(INDEX_BITS),
        .DATA_BITS(INDEX_BITS)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(idx_reg),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = OUT_TDATA_W'({cap_reg, ok_reg, ogen_reg, oidx_reg, status_reg});

    assign out_free  = !m_valid_reg || m_tready;
    assign fc_minus1 = free_count_reg - 1'b1;
    // The top of the free list is read on every cycle, so it is ready when a create arrives.
    assign stk_raddr = fc_minus1[INDEX_BITS-1:0];
    assign stk_waddr = free_count_reg[INDEX_BITS-1:0];
    assign gen_inc   = {1'b0, hgen_reg} + 1'b1;
    assign live      = ({1'b0, idx_reg} < high_water_reg) && (gen_rdata == {1'b1, hgen_reg});

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        hgen_next       = hgen_reg;
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        read_only_next  = cfg_valid ? cfg_data : read_only_reg;
        gen_raddr       = gen_addr_reg;
        gen_we          = 1'b0;
        gen_waddr       = idx_reg;
        gen_wdata       = '0;
        stk_we          = 1'b0;
        out_load        = 1'b0;
        status_next     = ST_OK;
        oidx_next       = NULL_INDEX;
        ogen_next       = GEN_MAX;
        ok_next         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = opcode_t'(s_tdata[OP_W-1:0]);
                    idx_next   = s_tdata[OP_W +: INDEX_BITS];
                    hgen_next  = s_tdata[OP_W + INDEX_BITS +: GEN_BITS];
                    gen_raddr  = s_tdata[OP_W +: INDEX_BITS];
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                if (op_reg == OP_CREATE && !read_only_reg && free_count_reg != '0)
                begin
                    // Popped index comes back now; fetch its generation word next.
                    gen_raddr  = stk_rdata;
                    state_next = S_RD2;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_CREATE:
                        begin
                            if (read_only_reg)
                            begin
                                status_next = ST_READ_ONLY;
                            end
                            else if (high_water_reg < {1'b0, NULL_INDEX})
                            begin
                                gen_we          = 1'b1;
                                gen_waddr       = high_water_reg[INDEX_BITS-1:0];
                                gen_wdata       = {1'b1, {GEN_BITS{1'b0}}};
                                high_water_next = high_water_reg + 1'b1;
                                oidx_next       = high_water_reg[INDEX_BITS-1:0];
                                ogen_next       = '0;
                            end
                            else
                            begin
                                status_next = ST_EXHAUSTED;
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (read_only_reg)
                            begin
                                status_next = ST_READ_ONLY;
                            end
                            else if (!live)
                            begin
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                gen_we    = 1'b1;
                                gen_wdata = {1'b0, gen_inc[GEN_BITS-1:0]};
                                // An index whose generation runs up to all ones is retired.
                                if (gen_inc < {1'b0, GEN_MAX} && !free_count_reg[INDEX_BITS])
                                begin
                                    stk_we          = 1'b1;
                                    free_count_next = free_count_reg + 1'b1;
                                end
                            end
                        end
                        OP_CHECK:
                        begin
                            ok_next = live;
                        end
                        OP_READ:
                        begin
                            if ({1'b0, idx_reg} >= high_water_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (gen_rdata[GEN_BITS])
                            begin
                                oidx_next = idx_reg;
                                ogen_next = gen_rdata[GEN_BITS-1:0];
                                ok_next   = 1'b1;
                            end
                        end
                        OP_RESET_ALL:
                        begin
                            free_count_next = '0;
                            high_water_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD2:
            begin
                if (out_free)
                begin
                    gen_we          = 1'b1;
                    gen_waddr       = gen_addr_reg;
                    gen_wdata       = {1'b1, gen_rdata[GEN_BITS-1:0]};
                    free_count_next = fc_minus1;
                    oidx_next       = gen_addr_reg;
                    ogen_next       = gen_rdata[GEN_BITS-1:0];
                    out_load        = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        gen_addr_next = gen_raddr;
        cap_next      = high_water_next[INDEX_BITS-1:0];
        m_valid_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            high_water_reg <= '0;
            read_only_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            read_only_reg  <= read_only_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        hgen_reg     <= hgen_next;
        gen_addr_reg <= gen_addr_next;
        if (out_load)
        begin
            status_reg <= status_next;
            oidx_reg   <= oidx_next;
            ogen_reg   <= ogen_next;
            ok_reg     <= ok_next;
            cap_reg    <= cap_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/gha_checker.sv */
// Port-level checker for the handle allocator, attached to the top level by bind.
// Depends on gha_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_allocator_top_assert.svh"

module gha_checker #(
    parameter int INDEX_BITS = gha_pkg::INDEX_BITS_DEF,
    parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
    parameter int OUT_TDATA_W = 40
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    import gha_pkg::*;

    localparam int IDX_LSB = ST_W;
    localparam int GEN_LSB = ST_W + INDEX_BITS;
    localparam int OK_BIT  = ST_W + INDEX_BITS + GEN_BITS;

    // A waiting result must not change or vanish.
    `GHA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // Items are processed one at a time, so requests are never taken back to back.
    `GHA_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // Every error result carries the null handle.
    `GHA_ASSERT_NOW(a_error_null, clk, rst_n, m_tvalid && m_tdata[ST_W-1:0] != ST_OK,
        m_tdata[IDX_LSB +: INDEX_BITS] == {INDEX_BITS{1'b1}} &&
        m_tdata[GEN_LSB +: GEN_BITS] == {GEN_BITS{1'b1}})

    // A live handle is only reported with an ok status.
    `GHA_ASSERT_NOW(a_ok_status, clk, rst_n, m_tvalid && m_tdata[OK_BIT],
        m_tdata[ST_W-1:0] == ST_OK)

endmodule

bind generational_handle_allocator_top gha_checker #(
    .INDEX_BITS (INDEX_BITS),
    .GEN_BITS   (GEN_BITS),
    .OUT_TDATA_W(OUT_TDATA_W)
) u_gha_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
